[rtl/mp2d_pkg.sv]
// Shared constants and types for the 2-D max-pooling block.
// No dependencies; imported by max_pool_2d_window.
package mp2d_pkg;

  localparam int unsigned CFG_W = 7;       // widest configuration register
  localparam int unsigned CIDX_W = 2;      // configuration register index width
  localparam int unsigned SAMPLE_W = 32;   // Q16.16 sample width
  localparam int unsigned COORD_W = 6;     // row / col field width
  localparam int unsigned POS_W = 11;      // window position width (origin plus step)
  localparam int unsigned SIZE_W = 5;      // saturated window side, up to 15
  localparam int unsigned IN_TDATA_W = 48; // row, col, sample padded to bytes
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [CIDX_W-1:0] {
    CFG_IN_HEIGHT = 2'd0,
    CFG_IN_WIDTH  = 2'd1,
    CFG_POOL_SIZE = 2'd2,
    CFG_STRIDE    = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_POOL  = 1'b1
  } opcode_t;

  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 32'sh8000_0000;

  localparam logic [6:0] RST_IN_HEIGHT = 7'd64;
  localparam logic [6:0] RST_IN_WIDTH  = 7'd64;
  localparam logic [3:0] RST_POOL_SIZE = 4'd2;
  localparam logic [3:0] RST_STRIDE    = 4'd2;

endpackage

[rtl/mp2d_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; used for the frame memory of max_pool_2d_window.
module mp2d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/max_pool_2d_window.sv]
// Max pooling over one feature map held in a frame memory (mp2d_ram).
// Write item: no result; the next item may follow at once.
// Pool item: one scan step per window position (side squared, side capped at MAX_POOL),
// with a read only for positions inside the map, then a read drain and the result
// load; an empty window goes straight to the result load. A result still held
// downstream stalls the load, and the next item is taken after it. rst (synchronous)
// restores register defaults and clears the sequencer and output slot; the frame
// memory holds its contents and needs no clearing.
module max_pool_2d_window #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_POOL = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mp2d_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [mp2d_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mp2d_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row[5:0], col[11:6], sample[43:12]
  input  logic                               s_axis_tuser,  // opcode
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mp2d_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // pool_max[31:0]
  output logic                               m_axis_tuser   // window_hit
);

  import mp2d_pkg::*;

  // Frame address is {row, col}; each part is as wide as its bound needs.
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  // Window step counters count 0 .. MAX_POOL-1.
  localparam int unsigned SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Configuration registers
  logic [6:0] map_height;
  logic [6:0] map_width;
  logic [3:0] win_side;
  logic [3:0] stride;

  // Sequencer state
  state_t               state;
  logic [POS_W-1:0]     org_r;
  logic [POS_W-1:0]     org_c;
  logic [POS_W-1:0]     rows_lim;
  logic [POS_W-1:0]     cols_lim;
  logic [SIZE_W-1:0]    size;
  logic [SW-1:0]        row_step;
  logic [SW-1:0]        col_step;
  logic signed [SAMPLE_W-1:0] running_max;
  logic                 any_inside;
  logic                 rd_pend;   // read data of an inside position arrives this cycle

  // Input field unpacking
  logic [COORD_W-1:0]  in_row;
  logic [COORD_W-1:0]  in_col;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_fire;

  assign in_row    = s_axis_tdata[COORD_W-1:0];
  assign in_col    = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_sample = s_axis_tdata[2*COORD_W+SAMPLE_W-1:2*COORD_W];

  // One item in flight at a time; the output register lets the next item in
  // while a result still waits downstream.
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Write path: drop writes that fall outside the memory.
  logic [POS_W-1:0] wr_row;
  logic [POS_W-1:0] wr_col;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;

  assign wr_row    = POS_W'(in_row);
  assign wr_col    = POS_W'(in_col);
  assign ram_we    = in_fire && (s_axis_tuser == OP_WRITE) &&
                     (wr_row < POS_W'(MAX_ROWS)) && (wr_col < POS_W'(MAX_COLS));
  assign ram_waddr = {wr_row[RW-1:0], wr_col[CW-1:0]};

  // Pool setup: saturate window, clamp limits, form the origin.
  logic [SIZE_W-1:0] size_next;
  logic [POS_W-1:0]  rows_lim_next;
  logic [POS_W-1:0]  cols_lim_next;

  assign size_next = (SIZE_W'(win_side) > SIZE_W'(MAX_POOL)) ?
                     SIZE_W'(MAX_POOL) : SIZE_W'(win_side);
  assign rows_lim_next = (POS_W'(map_height) > POS_W'(MAX_ROWS)) ?
                         POS_W'(MAX_ROWS) : POS_W'(map_height);
  assign cols_lim_next = (POS_W'(map_width) > POS_W'(MAX_COLS)) ?
                         POS_W'(MAX_COLS) : POS_W'(map_width);

  // Scan address of the current window position
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_c;
  logic             pos_inside;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic             col_last;
  logic             row_last;

  assign pos_r      = org_r + POS_W'(row_step);
  assign pos_c      = org_c + POS_W'(col_step);
  assign pos_inside = (pos_r < rows_lim) && (pos_c < cols_lim);
  assign ram_re     = (state == S_SCAN) && pos_inside;
  assign ram_raddr  = {pos_r[RW-1:0], pos_c[CW-1:0]};
  assign col_last   = (SIZE_W'(col_step) + SIZE_W'(1)) == size;
  assign row_last   = (SIZE_W'(row_step) + SIZE_W'(1)) == size;

  mp2d_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_height <= RST_IN_HEIGHT;
      map_width  <= RST_IN_WIDTH;
      win_side   <= RST_POOL_SIZE;
      stride     <= RST_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_IN_HEIGHT: map_height <= cfg_data[6:0];
        CFG_IN_WIDTH:  map_width  <= cfg_data[6:0];
        CFG_POOL_SIZE: win_side   <= cfg_data[3:0];
        CFG_STRIDE:    stride     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Window origin product; registered at acceptance.
  logic [POS_W-1:0] org_r_next;
  logic [POS_W-1:0] org_c_next;

  assign org_r_next = POS_W'(in_row) * POS_W'(stride);
  assign org_c_next = POS_W'(in_col) * POS_W'(stride);

  // Load the result once the output slot is free or being emptied.
  logic res_load;

  assign res_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_step      <= '0;
      col_step      <= '0;
      running_max   <= MOST_NEG;
      any_inside    <= 1'b0;
      rd_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Hold a new result, else drop the one just taken.
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // Fold in read data of the previous cycle.
      if (rd_pend) begin
        any_inside <= 1'b1;
        if ($signed(ram_rdata) > running_max) begin
          running_max <= $signed(ram_rdata);
        end
      end
      rd_pend <= ram_re;

      case (state)
        S_IDLE: begin
          if (in_fire && (s_axis_tuser == OP_POOL)) begin
            org_r       <= org_r_next;
            org_c       <= org_c_next;
            rows_lim    <= rows_lim_next;
            cols_lim    <= cols_lim_next;
            size        <= size_next;
            row_step    <= '0;
            col_step    <= '0;
            running_max <= MOST_NEG;
            any_inside  <= 1'b0;
            // An empty window scans nothing.
            state <= (size_next == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance column, then row; last position hands over to drain.
          if (col_last) begin
            col_step <= '0;
            if (row_last) begin
              row_step <= '0;
              state    <= S_DRAIN;
            end else begin
              row_step <= row_step + SW'(1);
            end
          end else begin
            col_step <= col_step + SW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            m_axis_tdata  <= running_max;
            m_axis_tuser  <= any_inside;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
